/* sv/fpps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpps_pkg;

	localparam int unsigned FLASH_PAGE_TOTAL  = 256;
	localparam int unsigned BUFFER_PAGE_TOTAL = 2;

	localparam logic [16:0] FLASH_PAGE_LIMIT  = 17'(FLASH_PAGE_TOTAL);
	localparam logic [8:0]  BUFFER_PAGE_LIMIT = 9'(BUFFER_PAGE_TOTAL);

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_DONE  = 2'd1;
	localparam logic [1:0] ACT_ERROR = 2'd2;
	localparam logic [1:0] ACT_POLL  = 2'd3;

	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_ERASE   = 2'd1;
	localparam logic [1:0] CMD_PROGRAM = 2'd2;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_REQUEST    = 2'd1;
	localparam logic [1:0] ERR_ERASE      = 2'd2;
	localparam logic [1:0] ERR_PROGRAM    = 2'd3;

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 40;

	// result item, packed from the highest bit down
	typedef struct packed {
		logic [1:0]  report_error;
		logic        report_done;
		logic        report_valid;
		logic [15:0] command_buffer_page;
		logic [15:0] command_flash_page;
		logic [1:0]  command;
	} result_t;

endpackage

`default_nettype wire

/* sv/flash_page_program_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser: action; tdata: start, count, buffer page, accepted
// m_*       out  m_tvalid/m_tready   tdata: command, pages, report fields
// apb       in   psel/penable        first_writable_page at address 0
//
// one item accepted per cycle unless the output stalls; its result passes the input register, then the output register
// the sequence state is updated as the input register hands its item to the output register
// a stalled output holds its result; the input register then fills and s_tready drops
// arst_n clears the phase, the sequence registers, the valid flags and the config register

module flash_page_program_sequencer
	import fpps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // start_page, page_count, source_buffer_page, issue_accepted, zero pad
	input  wire logic [1:0]            s_tuser,   // action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // command, command_flash_page, command_buffer_page, report_valid, report_done, report_error, zero pad
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_ERASE = 3'd1;
	localparam logic [2:0] PH_PROG  = 3'd2;
	localparam logic [2:0] PH_OK    = 3'd3;
	localparam logic [2:0] PH_FAIL  = 3'd4;

	logic [7:0]  first_page_q;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] start_s1;
	logic [15:0] count_s1;
	logic [7:0]  bufp_s1;
	logic        acc_s1;

	logic [2:0]  phase_q,     phase_d;
	logic [15:0] cur_fp_q,    cur_fp_d;
	logic [15:0] cur_bp_q,    cur_bp_d;
	logic [15:0] req_start_q, req_start_d;
	logic [15:0] req_count_q, req_count_d;
	logic [7:0]  req_buf_q,   req_buf_d;
	logic [1:0]  fail_q,      fail_d;

	logic        out_valid_q;
	result_t     out_q;
	result_t     res;

	logic        advance;
	logic [16:0] end_page;
	logic [16:0] next_fp;
	logic        bad_req;

	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == 1'b0) ? {24'd0, first_page_q} : 32'd0;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			first_page_q <= pwdata[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			start_s1  <= s_tdata[15:0];
			count_s1  <= s_tdata[31:16];
			bufp_s1   <= s_tdata[39:32];
			acc_s1    <= s_tdata[40];
		end
	end

	assign end_page = {1'b0, req_start_q} + {1'b0, req_count_q};
	assign next_fp  = {1'b0, cur_fp_q} + 17'd1;
	assign bad_req  = (start_s1 < {8'd0, first_page_q})
		|| ({1'b0, start_s1} >= FLASH_PAGE_LIMIT)
		|| (({1'b0, start_s1} + {1'b0, count_s1}) > FLASH_PAGE_LIMIT)
		|| ({1'b0, bufp_s1} >= BUFFER_PAGE_LIMIT);

	always_comb begin
		res         = '0;
		phase_d     = phase_q;
		cur_fp_d    = cur_fp_q;
		cur_bp_d    = cur_bp_q;
		req_start_d = req_start_q;
		req_count_d = req_count_q;
		req_buf_d   = req_buf_q;
		fail_d      = fail_q;
		if (action_s1 == ACT_WRITE && phase_q == PH_IDLE) begin
			if (bad_req) begin
				res.report_valid = 1'b1;
				res.report_error = ERR_REQUEST;
			end else begin
				req_start_d            = start_s1;
				req_count_d            = count_s1;
				req_buf_d              = bufp_s1;
				cur_fp_d               = start_s1;
				cur_bp_d               = {8'd0, bufp_s1};
				res.command            = CMD_ERASE;
				res.command_flash_page = start_s1;
				if (acc_s1) begin
					phase_d = PH_ERASE;
				end else begin
					res.report_valid = 1'b1;
					res.report_error = ERR_REQUEST;
				end
			end
		end else if (action_s1 == ACT_WRITE || action_s1 == ACT_POLL) begin
			if (phase_q == PH_OK) begin
				res.report_valid = 1'b1;
				res.report_done  = 1'b1;
				phase_d          = PH_IDLE;
			end else if (phase_q == PH_FAIL) begin
				res.report_valid = 1'b1;
				res.report_error = fail_q;
				phase_d          = PH_IDLE;
			end
		end else if (action_s1 == ACT_DONE) begin
			unique case (phase_q)
				PH_ERASE: begin
					if (next_fp < end_page) begin
						cur_fp_d               = next_fp[15:0];
						res.command            = CMD_ERASE;
						res.command_flash_page = next_fp[15:0];
						if (!acc_s1) begin
							fail_d  = ERR_ERASE;
							phase_d = PH_FAIL;
						end
					end else begin
						cur_fp_d                = req_start_q;
						cur_bp_d                = {8'd0, req_buf_q};
						phase_d                 = PH_PROG;
						res.command             = CMD_PROGRAM;
						res.command_flash_page  = req_start_q;
						res.command_buffer_page = {8'd0, req_buf_q};
						if (!acc_s1) begin
							fail_d  = ERR_PROGRAM;
							phase_d = PH_FAIL;
						end
					end
				end
				PH_PROG: begin
					cur_fp_d = next_fp[15:0];
					cur_bp_d = cur_bp_q + 16'd1;
					if (next_fp < end_page) begin
						res.command             = CMD_PROGRAM;
						res.command_flash_page  = next_fp[15:0];
						res.command_buffer_page = cur_bp_q + 16'd1;
						if (!acc_s1) begin
							fail_d  = ERR_PROGRAM;
							phase_d = PH_FAIL;
						end
					end else begin
						phase_d = PH_OK;
					end
				end
				default: begin
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_ERASE: begin
					res.command            = CMD_ERASE;
					res.command_flash_page = cur_fp_q;
					if (!acc_s1) begin
						fail_d  = ERR_ERASE;
						phase_d = PH_FAIL;
					end
				end
				PH_PROG: begin
					res.command             = CMD_PROGRAM;
					res.command_flash_page  = cur_fp_q;
					res.command_buffer_page = cur_bp_q;
					if (!acc_s1) begin
						fail_d  = ERR_PROGRAM;
						phase_d = PH_FAIL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cur_fp_q    <= '0;
			cur_bp_q    <= '0;
			req_start_q <= '0;
			req_count_q <= '0;
			req_buf_q   <= '0;
			fail_q      <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			cur_fp_q    <= cur_fp_d;
			cur_bp_q    <= cur_bp_d;
			req_start_q <= req_start_d;
			req_count_q <= req_count_d;
			req_buf_q   <= req_buf_d;
			fail_q      <= fail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

/* sv/fpps_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpps_chk
	import fpps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata
);

	result_t r;
	assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// no command code beyond program
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r.command == CMD_NONE || r.command == CMD_ERASE
			|| r.command == CMD_PROGRAM))
		else $error("bad command code");

	// idle result carries zero pages
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.command == CMD_NONE |->
			r.command_flash_page == 16'd0 && r.command_buffer_page == 16'd0)
		else $error("pages set without command");

	// report fields only with a report, done never with an error
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r.report_valid || (!r.report_done && r.report_error == ERR_NONE))
			&& !(r.report_done && r.report_error != ERR_NONE))
		else $error("inconsistent report");

	// a command with a report is only the refused first erase
	a_cmdrep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.report_valid && r.command != CMD_NONE |->
			r.command == CMD_ERASE && r.report_error == ERR_REQUEST)
		else $error("command with unexpected report");

endmodule

bind flash_page_program_sequencer fpps_chk u_fpps_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
